### src/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg - price level book shared definitions
// Widths, beat payloads, controller/datapath command and status, FSM codes.
// ----------------------------------------------------------------------------
package plb_pkg;

	localparam int LEVELS  = 256;
	localparam int IDX_W   = $clog2(LEVELS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int PRICE_W = 32;
	localparam int AMT_W   = 31;
	localparam int STAMP_W = 64;
	localparam int ENTRY_W = PRICE_W + AMT_W;

	localparam logic MODE_CLEAR = 1'b0;
	localparam logic MODE_SET   = 1'b1;
	localparam logic SIDE_ASK   = 1'b0;
	localparam logic SIDE_BID   = 1'b1;

	typedef struct packed {
		logic               mode;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [AMT_W-1:0]   amount;
		logic [STAMP_W-1:0] stamp;
		logic               last_in_message;
	} in_item_t;

	typedef struct packed {
		logic [STAMP_W-1:0] book_stamp;
		logic [PRICE_W-1:0] best_bid_price;
		logic [AMT_W-1:0]   best_bid_amount;
		logic               bid_present;
		logic [PRICE_W-1:0] best_ask_price;
		logic [AMT_W-1:0]   best_ask_amount;
		logic               ask_present;
		logic               overflowed;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic item_last;
		logic out_busy;
	} dp_status_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

endpackage

### src/plb_if.sv
// ----------------------------------------------------------------------------
// plb_in_if / plb_out_if - valid/ready channels
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface plb_in_if;
	logic              valid;
	logic              ready;
	plb_pkg::in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface plb_out_if;
	logic               valid;
	logic               ready;
	plb_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### src/plb_ctrl.sv
// ----------------------------------------------------------------------------
// plb_ctrl - price level book controller
// Sequences accept, table scan and finish of one beat at a time.
// ----------------------------------------------------------------------------
module plb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_mode,
	output logic                in_ready,
	output plb_pkg::dp_cmd_t    cmd,
	input  plb_pkg::dp_status_t status
);

	plb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= plb_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			plb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_mode == plb_pkg::MODE_SET) ? plb_pkg::ST_SCAN
					                                          : plb_pkg::ST_FINISH;
				end
			end
			plb_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) state_d = plb_pkg::ST_FINISH;
			end
			plb_pkg::ST_FINISH: begin
				if (!(status.item_last && status.out_busy)) begin
					cmd.finish = 1'b1;
					state_d    = plb_pkg::ST_IDLE;
				end
			end
			default: state_d = plb_pkg::ST_IDLE;
		endcase
	end

endmodule

### src/plb_dp.sv
// ----------------------------------------------------------------------------
// plb_dp - price level book datapath
// Level tables, used bits, scan pipeline, best-price folding, result register.
// ----------------------------------------------------------------------------
module plb_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  plb_pkg::dp_cmd_t     cmd,
	output plb_pkg::dp_status_t  status,
	input  plb_pkg::in_item_t    in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output plb_pkg::out_item_t   out_item
);

	localparam int IW = plb_pkg::IDX_W;
	localparam int PW = plb_pkg::PRICE_W;
	localparam int AW = plb_pkg::AMT_W;
	localparam int N  = plb_pkg::LEVELS;

	logic [plb_pkg::ENTRY_W-1:0] ask_mem [N];
	logic [plb_pkg::ENTRY_W-1:0] bid_mem [N];
	logic [N-1:0] ask_used_q, bid_used_q;

	plb_pkg::in_item_t item_q;
	logic [plb_pkg::CNT_W-1:0] cnt_q;
	logic rvalid_s1;
	logic [IW-1:0] ridx_s1;
	logic ask_used_s1, bid_used_s1;
	logic [plb_pkg::ENTRY_W-1:0] ask_rd_s1, bid_rd_s1;

	logic ask_found_q, bid_found_q;
	logic [PW-1:0] ask_price_q, bid_price_q;
	logic [AW-1:0] ask_amt_q, bid_amt_q;
	logic match_q, free_found_q, overflow_q;
	logic [IW-1:0] match_idx_q, free_idx_q;
	logic out_vq;
	plb_pkg::out_item_t out_q;

	logic target, tgt_ask, tgt_bid, amt_zero;
	logic [PW-1:0] ap, bp;
	logic [AW-1:0] aa, ba;
	logic a_hit, b_hit, hit, a_cv, b_cv, t_free;
	logic [AW-1:0] a_ca, b_ca;
	logic ins, ovf;
	logic ask_fv, bid_fv;
	logic [PW-1:0] ask_fp, bid_fp;
	logic [AW-1:0] ask_fa, bid_fa;

	assign target   = (item_q.mode == plb_pkg::MODE_SET) && (item_q.price != '0);
	assign tgt_ask  = target && (item_q.side == plb_pkg::SIDE_ASK);
	assign tgt_bid  = target && (item_q.side == plb_pkg::SIDE_BID);
	assign amt_zero = (item_q.amount == '0);

	assign ap = ask_rd_s1[plb_pkg::ENTRY_W-1 -: PW];
	assign aa = ask_rd_s1[AW-1:0];
	assign bp = bid_rd_s1[plb_pkg::ENTRY_W-1 -: PW];
	assign ba = bid_rd_s1[AW-1:0];

	assign a_hit  = tgt_ask && ask_used_s1 && (ap == item_q.price);
	assign b_hit  = tgt_bid && bid_used_s1 && (bp == item_q.price);
	assign hit    = a_hit || b_hit;
	assign a_cv   = ask_used_s1 && !(a_hit && amt_zero);
	assign b_cv   = bid_used_s1 && !(b_hit && amt_zero);
	assign a_ca   = a_hit ? item_q.amount : aa;
	assign b_ca   = b_hit ? item_q.amount : ba;
	assign t_free = (tgt_ask && !ask_used_s1) || (tgt_bid && !bid_used_s1);

	assign ins = target && !match_q && !amt_zero && free_found_q;
	assign ovf = target && !match_q && !amt_zero && !free_found_q;

	always_comb begin
		ask_fv = ask_found_q; ask_fp = ask_price_q; ask_fa = ask_amt_q;
		bid_fv = bid_found_q; bid_fp = bid_price_q; bid_fa = bid_amt_q;
		if (ins && tgt_ask && (!ask_found_q || item_q.price < ask_price_q)) begin
			ask_fv = 1'b1; ask_fp = item_q.price; ask_fa = item_q.amount;
		end
		if (ins && tgt_bid && (!bid_found_q || item_q.price > bid_price_q)) begin
			bid_fv = 1'b1; bid_fp = item_q.price; bid_fa = item_q.amount;
		end
	end

	assign status.scan_done = rvalid_s1 && (ridx_s1 == IW'(N - 1));
	assign status.item_last = item_q.last_in_message;
	assign status.out_busy  = out_vq && !out_ready;

	// table memories: scan reads, finish writes
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			ask_rd_s1 <= ask_mem[cnt_q[IW-1:0]];
			bid_rd_s1 <= bid_mem[cnt_q[IW-1:0]];
		end
		if (cmd.finish) begin
			if (ins && tgt_ask) ask_mem[free_idx_q] <= {item_q.price, item_q.amount};
			if (ins && tgt_bid) bid_mem[free_idx_q] <= {item_q.price, item_q.amount};
			if (match_q && !amt_zero && tgt_ask)
				ask_mem[match_idx_q] <= {item_q.price, item_q.amount};
			if (match_q && !amt_zero && tgt_bid)
				bid_mem[match_idx_q] <= {item_q.price, item_q.amount};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.scan) ridx_s1 <= cnt_q[IW-1:0];
		if (cmd.finish && item_q.last_in_message) begin
			out_q.book_stamp      <= item_q.stamp;
			out_q.best_bid_price  <= bid_fp;
			out_q.best_bid_amount <= bid_fa;
			out_q.bid_present     <= bid_fv;
			out_q.best_ask_price  <= ask_fp;
			out_q.best_ask_amount <= ask_fa;
			out_q.ask_present     <= ask_fv;
			out_q.overflowed      <= overflow_q || ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ask_used_q   <= '0;
			bid_used_q   <= '0;
			cnt_q        <= '0;
			rvalid_s1    <= 1'b0;
			ask_used_s1  <= 1'b0;
			bid_used_s1  <= 1'b0;
			ask_found_q  <= 1'b0;
			bid_found_q  <= 1'b0;
			ask_price_q  <= '0;
			bid_price_q  <= '0;
			ask_amt_q    <= '0;
			bid_amt_q    <= '0;
			match_q      <= 1'b0;
			free_found_q <= 1'b0;
			match_idx_q  <= '0;
			free_idx_q   <= '0;
			overflow_q   <= 1'b0;
			out_vq       <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q        <= '0;
				ask_found_q  <= 1'b0;
				bid_found_q  <= 1'b0;
				ask_price_q  <= '0;
				bid_price_q  <= '0;
				ask_amt_q    <= '0;
				bid_amt_q    <= '0;
				match_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			rvalid_s1 <= 1'b0;
			if (cmd.scan && (cnt_q < plb_pkg::CNT_W'(N))) begin
				rvalid_s1   <= 1'b1;
				ask_used_s1 <= ask_used_q[cnt_q[IW-1:0]];
				bid_used_s1 <= bid_used_q[cnt_q[IW-1:0]];
				cnt_q       <= cnt_q + 1'b1;
			end
			// fold one entry of each side
			if (rvalid_s1) begin
				if (hit) begin
					match_q     <= 1'b1;
					match_idx_q <= ridx_s1;
				end
				if (t_free && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= ridx_s1;
				end
				if (a_cv && (!ask_found_q || ap < ask_price_q)) begin
					ask_found_q <= 1'b1;
					ask_price_q <= ap;
					ask_amt_q   <= a_ca;
				end
				if (b_cv && (!bid_found_q || bp > bid_price_q)) begin
					bid_found_q <= 1'b1;
					bid_price_q <= bp;
					bid_amt_q   <= b_ca;
				end
			end
			if (cmd.finish) begin
				if (item_q.mode == plb_pkg::MODE_CLEAR) begin
					ask_used_q <= '0;
					bid_used_q <= '0;
				end
				if (ins && tgt_ask) ask_used_q[free_idx_q] <= 1'b1;
				if (ins && tgt_bid) bid_used_q[free_idx_q] <= 1'b1;
				if (match_q && amt_zero && tgt_ask) ask_used_q[match_idx_q] <= 1'b0;
				if (match_q && amt_zero && tgt_bid) bid_used_q[match_idx_q] <= 1'b0;
				if (ovf) overflow_q <= 1'b1;
			end
			if (cmd.finish && item_q.last_in_message) out_vq <= 1'b1;
			else if (out_ready)                        out_vq <= 1'b0;
		end
	end

	assign out_valid = out_vq;
	assign out_item  = out_q;

endmodule

### src/price_level_book_top.sv
// ----------------------------------------------------------------------------
// price_level_book_top - price level top of book
// Ask and bid level tables; reports best ask and best bid on message end.
// ----------------------------------------------------------------------------
//  channel  | dir | beat
//  items    | in  | mode, side, price, amount, stamp, last_in_message
//  results  | out | book_stamp, best bid/ask price and amount, present, overflowed
//
//  Level setting scans one table entry per cycle over a single memory read
//  port per side. Clear skips the scan and goes from accept to finish.
//  Reset clears used bits and flags at once; no clearing pass.
//  The result register holds while results stall; the next beat is taken, and
//  a beat that ends a message waits in finish until the held result moves.
// ----------------------------------------------------------------------------
module price_level_book_top (
	input  logic      clk,
	input  logic      arst_n,
	plb_in_if.sink    items,
	plb_out_if.source results
);

	plb_pkg::dp_cmd_t    cmd;
	plb_pkg::dp_status_t status;

	plb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_mode  (items.payload.mode),
		.in_ready (items.ready),
		.cmd      (cmd),
		.status   (status)
	);

	plb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_item   (items.payload),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_item  (results.payload)
	);

endmodule
